@@ design/rdpz_pkg.sv @@
// ----------------------------------------------------------------------------
// rdpz_pkg
// Widths, register indexes and the pipeline lane type shared by the
// ray-depth to planar-Z datapath.
// ----------------------------------------------------------------------------
package rdpz_pkg;

    localparam int DEPTH_BITS    = 16;
    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 4;
    localparam int CFG_BITS      = 16;
    localparam int CFG_ADDR_BITS = 2;

    localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int DIFF_BITS = (POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS;
    localparam int S_BITS    = 2 * DIFF_BITS + 2;
    localparam int P_BITS    = CFG_BITS + DEPTH_BITS;
    localparam int R_BITS    = 2 * P_BITS;
    localparam int ZS_BITS   = DEPTH_BITS + S_BITS;
    localparam int WIDE_BITS = 2 * DEPTH_BITS + S_BITS + 1;
    localparam int IDX_BITS  = $clog2(DEPTH_BITS);

    localparam logic [CFG_BITS-1:0] FOCAL_RESET    = CFG_BITS'(8192);
    localparam logic [CFG_BITS-1:0] CENTER_X_RESET = CFG_BITS'(5120);
    localparam logic [CFG_BITS-1:0] CENTER_Y_RESET = CFG_BITS'(3840);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FOCAL    = 2'd0,
        REG_CENTER_X = 2'd1,
        REG_CENTER_Y = 2'd2,
        REG_UNUSED   = 2'd3
    } rdpz_reg_t;

    // One item on its way through the root stages.
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [DEPTH_BITS-1:0] z;
        logic [ZS_BITS-1:0]    zs;
        logic [WIDE_BITS-1:0]  rem;
        logic [S_BITS-1:0]     s;
    } rdpz_lane_t;

endpackage

@@ design/rdpz_root_step.sv @@
// ----------------------------------------------------------------------------
// rdpz_root_step
// One bit of the quotient-root search: decides bit k of the largest z with
// z*z*S <= R, keeping the remainder R - z*z*S and the product z*S.
// ----------------------------------------------------------------------------
module rdpz_root_step (
    input  rdpz_pkg::rdpz_lane_t          lane_i,
    input  logic [rdpz_pkg::IDX_BITS-1:0] bit_pos,
    output rdpz_pkg::rdpz_lane_t          lane_o
);
    import rdpz_pkg::*;

    logic [WIDE_BITS-1:0] trial;
    logic                 take;

    // (z + 2^k)^2 * S - z^2 * S = z*S*2^(k+1) + S*2^(2k)
    always_comb begin
        trial = (WIDE_BITS'(lane_i.zs) << ({1'b0, bit_pos} + 1'b1))
              + (WIDE_BITS'(lane_i.s) << {bit_pos, 1'b0});
        take  = (lane_i.rem >= trial);
        lane_o = lane_i;
        if (take) begin
            lane_o.rem = lane_i.rem - trial;
            lane_o.z   = lane_i.z | (DEPTH_BITS'(1) << bit_pos);
            lane_o.zs  = lane_i.zs + (ZS_BITS'(lane_i.s) << bit_pos);
        end
    end

endmodule

@@ design/ray_depth_to_planar_z_core.sv @@
// ----------------------------------------------------------------------------
// ray_depth_to_planar_z_core
// Converts depth along the camera ray to planar Z depth:
// z = floor(f*d / sqrt((x-cx)^2 + (y-cy)^2 + f^2)).
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_depth_sample, s_pixel_col, s_pixel_row
// m_        out        m_valid / m_ready      m_planar_depth
// cfg_      in         cfg_valid / cfg_ready  cfg_addr, cfg_data
//
// One item per cycle unless the sink stalls: three arithmetic stages, then one
// root stage per result bit, the last one being the output register. The whole
// pipeline advances together whenever the output register is empty or taken,
// so a stall holds every stage. Reset clears the valid bits and loads the
// register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_depth_to_planar_z_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rdpz_pkg::DEPTH_BITS-1:0]     s_depth_sample,
    input  logic [rdpz_pkg::COORD_BITS-1:0]     s_pixel_col,
    input  logic [rdpz_pkg::COORD_BITS-1:0]     s_pixel_row,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rdpz_pkg::DEPTH_BITS-1:0]     m_planar_depth,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdpz_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [rdpz_pkg::CFG_BITS-1:0]       cfg_data
);
    import rdpz_pkg::*;

    logic [CFG_BITS-1:0] focal_reg, center_x_reg, center_y_reg;

    // Stage A: differences.
    logic                  a_valid_reg, a_zero_reg;
    logic [DIFF_BITS-1:0]  a_dx_reg, a_dy_reg;
    logic [CFG_BITS-1:0]   a_f_reg;
    logic [DEPTH_BITS-1:0] a_d_reg;
    // Stage B: products.
    logic                   b_valid_reg, b_zero_reg;
    logic [2*DIFF_BITS-1:0] b_dx2_reg, b_dy2_reg, b_ff_reg;
    logic [P_BITS-1:0]      b_p_reg;

    rdpz_lane_t lane_reg  [0:DEPTH_BITS];
    rdpz_lane_t lane_next [1:DEPTH_BITS];

    logic                 advance;
    logic [POS_BITS-1:0]  pos_x, pos_y;
    logic [DIFF_BITS-1:0] ex, ey, ecx, ecy;
    logic [DIFF_BITS-1:0] dx_next, dy_next;

    assign advance   = !lane_reg[DEPTH_BITS].valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = lane_reg[DEPTH_BITS].valid;
    assign m_planar_depth = lane_reg[DEPTH_BITS].zero ? '0 : lane_reg[DEPTH_BITS].z;

    always_comb begin
        pos_x   = {s_pixel_col, {FRAC_BITS{1'b0}}};
        pos_y   = {s_pixel_row, {FRAC_BITS{1'b0}}};
        ex      = DIFF_BITS'(pos_x);
        ey      = DIFF_BITS'(pos_y);
        ecx     = DIFF_BITS'(center_x_reg);
        ecy     = DIFF_BITS'(center_y_reg);
        dx_next = (ex >= ecx) ? ex - ecx : ecx - ex;
        dy_next = (ey >= ecy) ? ey - ecy : ecy - ey;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg    <= FOCAL_RESET;
            center_x_reg <= CENTER_X_RESET;
            center_y_reg <= CENTER_Y_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_FOCAL:    focal_reg    <= cfg_data;
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_zero_reg <= (focal_reg == '0) || (s_depth_sample == '0);
            a_dx_reg   <= dx_next;
            a_dy_reg   <= dy_next;
            a_f_reg    <= focal_reg;
            a_d_reg    <= s_depth_sample;

            b_zero_reg <= a_zero_reg;
            b_dx2_reg  <= (2*DIFF_BITS)'(a_dx_reg) * (2*DIFF_BITS)'(a_dx_reg);
            b_dy2_reg  <= (2*DIFF_BITS)'(a_dy_reg) * (2*DIFF_BITS)'(a_dy_reg);
            b_ff_reg   <= (2*DIFF_BITS)'(a_f_reg) * (2*DIFF_BITS)'(a_f_reg);
            b_p_reg    <= P_BITS'(a_f_reg) * P_BITS'(a_d_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg[0] <= '0;
        end else if (advance) begin
            lane_reg[0].valid <= b_valid_reg;
            lane_reg[0].zero  <= b_zero_reg;
            lane_reg[0].z     <= '0;
            lane_reg[0].zs    <= '0;
            lane_reg[0].s     <= S_BITS'(b_dx2_reg) + S_BITS'(b_dy2_reg)
                               + S_BITS'(b_ff_reg);
            lane_reg[0].rem   <= WIDE_BITS'(R_BITS'(b_p_reg) * R_BITS'(b_p_reg));
        end
    end

    // Root stages, most significant result bit first.
    for (genvar i = 0; i < DEPTH_BITS; i++) begin : g_root
        rdpz_root_step u_step (
            .lane_i  (lane_reg[i]),
            .bit_pos (IDX_BITS'(DEPTH_BITS - 1 - i)),
            .lane_o  (lane_next[i+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lane_reg[i+1] <= '0;
            end else if (advance) begin
                lane_reg[i+1] <= lane_next[i+1];
            end
        end
    end

    // A held result keeps its value while the sink stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_planar_depth))
        else $error("result changed during stall");

    // Input is ready exactly when the pipeline advances.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the pipeline enable");

    // An item flagged zero at the output reports zero depth.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && lane_reg[DEPTH_BITS].zero |-> m_planar_depth == '0)
        else $error("zero-flagged item gave nonzero depth");

    // At the output, the running product z*S equals the root times the squared ray norm.
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_reg[DEPTH_BITS].valid && !lane_reg[DEPTH_BITS].zero
            |-> lane_reg[DEPTH_BITS].zs ==
                ZS_BITS'(lane_reg[DEPTH_BITS].z) * ZS_BITS'(lane_reg[DEPTH_BITS].s))
        else $error("z*S bookkeeping mismatch");

endmodule
